// ===== rtl/sds_pkg.sv =====
// sds_pkg: shared types, constants and height decode for the sprite depth sort unit
`timescale 1ns / 1ps
package sds_pkg;

   localparam int ENTRIES_DEFAULT = 128;
   localparam int KEY_W = 32;
   localparam int PRIO_W = 8;
   localparam int ATTR_W = 64;
   localparam int HEIGHT_W = 7;
   localparam int FRAC_W = 16;

   typedef enum logic {
      OP_LOAD  = 1'b0,
      OP_FETCH = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_FIRST,
      S_CMP,
      S_END
   } sort_state_type;

   typedef struct packed {
      opcode_type          opcode;
      logic [PRIO_W-1:0]   group_priority;
      logic signed [31:0]  vertical_pos;
      logic [ATTR_W-1:0]   attr_word;
      logic                load_last;
   } req_type;

   typedef struct packed {
      logic [ATTR_W-1:0]   sorted_attr;
      logic                sorted_last;
   } rsp_type;

   typedef struct packed {
      logic [KEY_W-1:0]    key;
      logic [PRIO_W-1:0]   prio;
      logic [ATTR_W-1:0]   attr;
   } entry_type;

   // shape 3 is prohibited and adds nothing
   function automatic logic [HEIGHT_W-1:0] height_of(input logic [ATTR_W-1:0] attr);
      logic [1:0] shape;
      logic [1:0] size;
      logic [HEIGHT_W-1:0] h;
      shape = attr[15:14];
      size  = attr[31:30];
      h = '0;
      case (shape)
         2'd0: begin
            case (size)
               2'd0: h = 7'd8;
               2'd1: h = 7'd16;
               2'd2: h = 7'd32;
               default: h = 7'd64;
            endcase
         end
         2'd1: begin
            case (size)
               2'd0: h = 7'd8;
               2'd1: h = 7'd8;
               2'd2: h = 7'd16;
               default: h = 7'd32;
            endcase
         end
         2'd2: begin
            case (size)
               2'd0: h = 7'd16;
               2'd1: h = 7'd32;
               2'd2: h = 7'd32;
               default: h = 7'd64;
            endcase
         end
         default: h = '0;
      endcase
      return h;
   endfunction

   function automatic logic [KEY_W-1:0] bottom_key(input logic [31:0] pos,
                                                   input logic [ATTR_W-1:0] attr);
      logic [KEY_W-1:0] ext;
      ext = {{(KEY_W-HEIGHT_W-FRAC_W){1'b0}}, height_of(attr), {FRAC_W{1'b0}}};
      return pos + ext;
   endfunction

endpackage

// ===== rtl/sprite_depth_sort_unit.sv =====
// sprite_depth_sort_unit: sprite table load, in-memory bubble sort and sorted readout
// Usage: req beats with opcode load write one sprite entry each (priority, 16.16
// position, attribute word); the bottom key position + (height << 16) is formed on
// the way into the entry memory. A load with load_last set starts the sort: full
// bubble passes over the memory, swapping neighbours of equal priority whose first
// key is smaller (signed). Fetch beats then return attribute words in sorted order,
// sorted_last marking the final one; a fetch with nothing to give returns no beat.
// A load after a finished sort starts a new table.
// Timing: a fetch reads the memory into the read register and its rsp beat is then
// registered in the output register; a new fetch is not taken while a read is
// pending. During the sort req_stall is high; each pass runs S_FIRST, S_CMP for
// each neighbour pair and S_END, and covers one entry fewer than the pass before.
// Reset (synchronous) empties the table and clears the output valid; memory
// contents are left as they are. While rsp_stall is high the rsp beat holds and
// further req beats are stalled.
`timescale 1ns / 1ps
module sprite_depth_sort_unit #(
   parameter int ENTRIES = sds_pkg::ENTRIES_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  sds_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output sds_pkg::rsp_type rsp_data
);
   import sds_pkg::*;

   localparam int CW = $clog2(ENTRIES + 1);
   localparam int IW = $clog2(ENTRIES);

   entry_type mem [ENTRIES];
   entry_type mem_rd_ff;

   logic           mem_we;
   logic [IW-1:0]  mem_wr_addr;
   entry_type      mem_wr_data;
   logic [IW-1:0]  mem_rd_addr;

   sort_state_type state_ff, state_in;
   logic [CW-1:0]  count_ff, count_in;
   logic [CW-1:0]  rp_ff, rp_in;
   logic           sorted_ff, sorted_in;
   logic [CW-1:0]  pass_ff, pass_in;
   logic [CW-1:0]  j_ff, j_in;
   entry_type      held_ff, held_in;
   logic           pend_ff, pend_in;
   logic           pend_last_ff, pend_last_in;
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_type        rsp_data_ff;

   logic           accept;
   logic           swap;
   logic [CW-1:0]  count_eff;
   logic [CW-1:0]  count_load;

   // entry memory
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wr_addr] <= mem_wr_data;
      end
      mem_rd_ff <= mem[mem_rd_addr];
   end

   assign req_stall = (state_ff != S_IDLE) || pend_ff || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;
   assign count_eff = sorted_ff ? '0 : count_ff;
   assign count_load = (count_eff < CW'(ENTRIES)) ? count_eff + CW'(1) : count_eff;
   assign swap = (held_ff.prio == mem_rd_ff.prio) &&
                 ($signed(held_ff.key) < $signed(mem_rd_ff.key));

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rp_in        = rp_ff;
      sorted_in    = sorted_ff;
      pass_in      = pass_ff;
      j_in         = j_ff;
      held_in      = held_ff;
      pend_in      = 1'b0;
      pend_last_in = pend_last_ff;
      mem_we       = 1'b0;
      mem_wr_addr  = '0;
      mem_wr_data  = held_ff;
      mem_rd_addr  = '0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (pend_ff) begin
         rsp_valid_in = 1'b1;
      end
      case (state_ff)
         S_IDLE: begin
            if (accept && req_data.opcode == OP_LOAD) begin
               mem_we      = count_eff < CW'(ENTRIES);
               mem_wr_addr = count_eff[IW-1:0];
               mem_wr_data.key  = bottom_key(req_data.vertical_pos, req_data.attr_word);
               mem_wr_data.prio = req_data.group_priority;
               mem_wr_data.attr = req_data.attr_word;
               count_in  = count_load;
               rp_in     = '0;
               sorted_in = req_data.load_last;
               pass_in   = count_load;
               mem_rd_addr = '0;
               if (req_data.load_last && count_load >= CW'(2)) begin
                  state_in = S_FIRST;
               end
            end else if (accept && sorted_ff && rp_ff < count_ff) begin
               mem_rd_addr  = rp_ff[IW-1:0];
               pend_in      = 1'b1;
               pend_last_in = (rp_ff + CW'(1)) == count_ff;
               rp_in        = rp_ff + CW'(1);
            end
         end
         S_FIRST: begin
            held_in     = mem_rd_ff;
            mem_rd_addr = IW'(1);
            j_in        = '0;
            state_in    = S_CMP;
         end
         S_CMP: begin
            mem_we      = 1'b1;
            mem_wr_addr = j_ff[IW-1:0];
            mem_wr_data = swap ? mem_rd_ff : held_ff;
            held_in     = swap ? held_ff : mem_rd_ff;
            if (j_ff + CW'(2) == pass_ff) begin
               state_in = S_END;
            end else begin
               mem_rd_addr = IW'(j_ff + CW'(2));
               j_in        = j_ff + CW'(1);
            end
         end
         S_END: begin
            mem_we      = 1'b1;
            mem_wr_addr = IW'(pass_ff - CW'(1));
            mem_wr_data = held_ff;
            pass_in     = pass_ff - CW'(1);
            mem_rd_addr = '0;
            if (pass_ff - CW'(1) >= CW'(2)) begin
               state_in = S_FIRST;
            end else begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rp_ff        <= '0;
         sorted_ff    <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rp_ff        <= rp_in;
         sorted_ff    <= sorted_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pass_ff      <= pass_in;
      j_ff         <= j_in;
      held_ff      <= held_in;
      pend_last_ff <= pend_last_in;
      if (pend_ff) begin
         rsp_data_ff.sorted_attr <= mem_rd_ff.attr;
         rsp_data_ff.sorted_last <= pend_last_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== rtl/sds_checker.sv =====
// sds_checker: port-level assertions for the sprite depth sort unit and its bind
`timescale 1ns / 1ps
module sds_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input sds_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input sds_pkg::rsp_type rsp_data
);
   import sds_pkg::*;

   // stalled rsp beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("rsp beat changed under stall");

   // a load never produces a beat
   a_load_quiet: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.opcode == OP_LOAD && !rsp_valid |=> !rsp_valid)
      else $error("rsp beat after load");

   // a new rsp beat rises only after an accepted fetch, via the memory read and output registers
   a_rsp_from_fetch: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |->
         $past(req_valid && !req_stall && req_data.opcode == OP_FETCH, 2))
      else $error("rsp beat without fetch");

endmodule

bind sprite_depth_sort_unit sds_checker u_sds_checker (.*);
